[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// expression must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/core/mst_pkg.sv]
`default_nettype none
package mst_pkg;

   // field widths
   localparam int MODE_W    = 2;
   localparam int TEXT_W    = 12;
   localparam int SHOW_W    = 21;
   localparam int ELAPSED_W = 20;
   localparam int SCROLL_W  = 13;
   localparam int SPEED_W   = 10;
   localparam int CSR_ADDR_W = 2;

   // display geometry
   localparam logic [TEXT_W-1:0] DISPLAY_WIDTH  = 12'd32;
   localparam logic [TEXT_W-1:0] MAX_TEXT_WIDTH = 12'd4095;

   // event kinds
   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MESSAGE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESET   = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SCROLL_WAIT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCROLL_SPEED = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_SHOW = 2'd2;

   // register reset values
   localparam logic [SCROLL_W-1:0] SCROLL_WAIT_RST  = 13'd1000;
   localparam logic [SPEED_W-1:0]  SCROLL_SPEED_RST = 10'd50;
   localparam logic [SHOW_W-1:0]   SHOW_FOREVER     = '1;

   typedef struct packed {
      logic [SCROLL_W-1:0] scroll_wait;
      logic [SPEED_W-1:0]  scroll_speed;
      logic [SHOW_W-1:0]   default_show_time;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TEXT_W-1:0] text_width;
      logic [SHOW_W-1:0] show_time;
   } item_type;

   typedef struct packed {
      logic              reset_allowed;
      logic              showing;
      logic              cleared;
      logic              redraw;
      logic [TEXT_W-1:0] offset;
   } result_type;

endpackage
`default_nettype wire

[rtl/core/mst_engine.sv]
`default_nettype none
module mst_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire mst_pkg::item_type  item,
   input  wire mst_pkg::cfg_type   cfg,
   output mst_pkg::result_type     result
);

   logic                           is_showing_ff, is_showing_in;
   logic                           is_scrolling_ff, is_scrolling_in;
   logic [mst_pkg::TEXT_W-1:0]     pixel_offset_ff, pixel_offset_in;
   logic [mst_pkg::TEXT_W-1:0]     message_width_ff, message_width_in;
   logic [mst_pkg::SHOW_W-1:0]     show_limit_ff, show_limit_in;
   logic [mst_pkg::ELAPSED_W-1:0]  show_elapsed_ff, show_elapsed_in;
   logic [mst_pkg::SCROLL_W-1:0]   scroll_elapsed_ff, scroll_elapsed_in;

   logic [mst_pkg::ELAPSED_W-1:0]  show_inc;
   logic [mst_pkg::SCROLL_W-1:0]   scroll_inc;
   logic [mst_pkg::TEXT_W-1:0]     end_pos;
   logic [mst_pkg::TEXT_W-1:0]     width_clip;
   logic [mst_pkg::SHOW_W-1:0]     limit_pick;
   logic                           stop;
   logic                           wait_done;
   logic                           step_done;

   // saturating tick counters and show expiry
   assign show_inc   = (show_elapsed_ff != '1) ? show_elapsed_ff + 20'd1 : show_elapsed_ff;
   assign scroll_inc = (scroll_elapsed_ff != '1) ? scroll_elapsed_ff + 13'd1
                                                 : scroll_elapsed_ff;
   assign stop = is_showing_ff && (show_limit_ff != mst_pkg::SHOW_FOREVER)
                 && ({1'b0, show_inc} >= show_limit_ff);
   assign end_pos   = message_width_ff + 12'd2 - mst_pkg::DISPLAY_WIDTH;
   assign wait_done = scroll_inc >= cfg.scroll_wait;
   assign step_done = scroll_inc >= {3'b000, cfg.scroll_speed};

   // new message width and show time
   assign width_clip = (item.text_width > mst_pkg::MAX_TEXT_WIDTH) ? mst_pkg::MAX_TEXT_WIDTH
                                                                   : item.text_width;
   assign limit_pick = ((item.show_time == '0) ||
                        (item.show_time[mst_pkg::SHOW_W-1] &&
                         item.show_time != mst_pkg::SHOW_FOREVER))
                       ? cfg.default_show_time : item.show_time;

   // event decode
   always_comb begin
      is_showing_in     = is_showing_ff;
      is_scrolling_in   = is_scrolling_ff;
      pixel_offset_in   = pixel_offset_ff;
      message_width_in  = message_width_ff;
      show_limit_in     = show_limit_ff;
      show_elapsed_in   = show_elapsed_ff;
      scroll_elapsed_in = scroll_elapsed_ff;
      result.offset        = pixel_offset_ff;
      result.redraw        = 1'b0;
      result.cleared       = 1'b0;
      result.reset_allowed = 1'b0;
      unique case (item.mode)
         mst_pkg::MODE_TICK: begin
            show_elapsed_in   = show_inc;
            scroll_elapsed_in = scroll_inc;
            if (stop) begin
               is_showing_in   = 1'b0;
               is_scrolling_in = 1'b0;
               result.cleared  = 1'b1;
            end else if (is_scrolling_ff) begin
               // hold at both ends, step in between
               priority if (pixel_offset_ff == '0) begin
                  if (wait_done) begin
                     result.redraw     = 1'b1;
                     scroll_elapsed_in = '0;
                     pixel_offset_in   = 12'd1;
                  end
               end else if (pixel_offset_ff == end_pos) begin
                  if (wait_done) begin
                     result.redraw     = 1'b1;
                     scroll_elapsed_in = '0;
                     pixel_offset_in   = '0;
                  end
               end else if (step_done) begin
                  result.redraw     = 1'b1;
                  result.offset     = pixel_offset_ff + 12'd1;
                  scroll_elapsed_in = '0;
                  pixel_offset_in   = pixel_offset_ff + 12'd1;
               end
            end
         end
         mst_pkg::MODE_MESSAGE: begin
            show_limit_in     = limit_pick;
            message_width_in  = width_clip;
            is_scrolling_in   = width_clip > mst_pkg::DISPLAY_WIDTH;
            pixel_offset_in   = '0;
            show_elapsed_in   = '0;
            scroll_elapsed_in = '0;
            is_showing_in     = 1'b1;
            result.redraw     = 1'b1;
            result.offset     = '0;
         end
         mst_pkg::MODE_RESET: begin
            if (!is_showing_ff) begin
               result.reset_allowed = 1'b1;
            end else if (show_limit_ff == mst_pkg::SHOW_FOREVER) begin
               is_showing_in        = 1'b0;
               is_scrolling_in      = 1'b0;
               result.cleared       = 1'b1;
               result.reset_allowed = 1'b1;
            end
         end
         default: begin
         end
      endcase
      result.showing = is_showing_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         is_showing_ff     <= 1'b0;
         is_scrolling_ff   <= 1'b0;
         pixel_offset_ff   <= '0;
         message_width_ff  <= '0;
         show_limit_ff     <= '0;
         show_elapsed_ff   <= '0;
         scroll_elapsed_ff <= '0;
      end else if (fire) begin
         is_showing_ff     <= is_showing_in;
         is_scrolling_ff   <= is_scrolling_in;
         pixel_offset_ff   <= pixel_offset_in;
         message_width_ff  <= message_width_in;
         show_limit_ff     <= show_limit_in;
         show_elapsed_ff   <= show_elapsed_in;
         scroll_elapsed_ff <= scroll_elapsed_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/marquee_scroll_timer_core.sv]
// an accepted item passes through the input register and then the result register
// one item per cycle while the result side keeps rsp_tready high; the event update is combinational
// an input register and a result register let both sides stall independently
// reset (synchronous, active high) clears the banner state and loads
// the register defaults: scroll_wait 1000, scroll_speed 50, show time forever
`default_nettype none
`include "assert_macros.svh"
module marquee_scroll_timer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // text_width[11:0], show_time[32:12], zero fill
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // offset[11:0], redraw, cleared, showing,
                                         // reset_allowed
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [20:0] csr_wdata
);

   mst_pkg::cfg_type    cfg_ff;
   mst_pkg::item_type   inp_item_ff;
   logic                inp_valid_ff;
   mst_pkg::result_type out_data_ff;
   logic                out_valid_ff;
   mst_pkg::item_type   req_item;
   mst_pkg::result_type result;
   logic                move;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scroll_wait       <= mst_pkg::SCROLL_WAIT_RST;
         cfg_ff.scroll_speed      <= mst_pkg::SCROLL_SPEED_RST;
         cfg_ff.default_show_time <= mst_pkg::SHOW_FOREVER;
      end else if (csr_we) begin
         unique case (csr_addr)
            mst_pkg::CSR_SCROLL_WAIT:  cfg_ff.scroll_wait  <= csr_wdata[12:0];
            mst_pkg::CSR_SCROLL_SPEED: cfg_ff.scroll_speed <= csr_wdata[9:0];
            mst_pkg::CSR_DEFAULT_SHOW: cfg_ff.default_show_time <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // unpack the incoming item
   assign req_item.mode       = req_tuser;
   assign req_item.text_width = req_tdata[11:0];
   assign req_item.show_time  = req_tdata[32:12];

   // handshake: the input register moves whenever the result register frees
   assign move       = inp_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !inp_valid_ff || move;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         inp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         inp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         inp_item_ff <= req_item;
      end
   end

   // event engine holding the banner state
   mst_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (move),
      .item   (inp_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff.reset_allowed, out_data_ff.showing,
                        out_data_ff.cleared, out_data_ff.redraw, out_data_ff.offset};

   // checks
   `ASSERT_IMPLY(a_cleared_not_showing, clock, reset, out_valid_ff && out_data_ff.cleared, !out_data_ff.showing)
   `ASSERT_IMPLY(a_redraw_showing, clock, reset, out_valid_ff && out_data_ff.redraw, out_data_ff.showing)
   `ASSERT_ALWAYS(a_allowed_no_redraw, clock, reset, !(out_data_ff.reset_allowed && out_data_ff.redraw && out_valid_ff))
   `ASSERT_IMPLY(a_full_stall_blocks, clock, reset, inp_valid_ff && out_valid_ff && !rsp_tready, !req_tready)

endmodule
`default_nettype wire
